### hw/rtl/tce_pkg.sv
// tce_pkg: opcodes, field widths and fixed constants of the toy cpu execute unit
// no dependencies; imported by tce_div and toy_cpu_execute_unit_top
package tce_pkg;

  localparam int unsigned WORD_W   = 32;
  localparam int unsigned ADDR_W   = 24;
  localparam int unsigned NUM_REGS = 16;
  localparam int unsigned REG_IDX_W = $clog2(NUM_REGS);

  // pc advance for every instruction except exit and a taken branch
  localparam logic [WORD_W-1:0] PC_STEP = 32'd4;

  typedef logic [WORD_W-1:0]    word_t;
  typedef logic [REG_IDX_W-1:0] reg_idx_t;
  typedef logic [3:0]           opcode_t;

  localparam opcode_t OPC_LD   = 4'd0;
  localparam opcode_t OPC_ST   = 4'd1;
  localparam opcode_t OPC_ADD  = 4'd2;
  localparam opcode_t OPC_SUB  = 4'd3;
  localparam opcode_t OPC_MUL  = 4'd4;
  localparam opcode_t OPC_DIV  = 4'd5;
  localparam opcode_t OPC_AND  = 4'd6;
  localparam opcode_t OPC_OR   = 4'd7;
  localparam opcode_t OPC_XOR  = 4'd8;
  localparam opcode_t OPC_MOV  = 4'd9;
  localparam opcode_t OPC_CMP  = 4'd10;
  localparam opcode_t OPC_B    = 4'd11;
  localparam opcode_t OPC_BEQ  = 4'd12;
  localparam opcode_t OPC_BGT  = 4'd13;
  localparam opcode_t OPC_BLT  = 4'd14;
  localparam opcode_t OPC_EXIT = 4'd15;

endpackage

### hw/rtl/tce_div.sv
// tce_div: signed 32-bit divider, one quotient bit per cycle (restoring)
// depends on tce_pkg; divide by zero gives all ones
module tce_div
  import tce_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  start,
  input  word_t dividend,
  input  word_t divisor,
  output logic  done,
  output word_t quotient
);

  logic                  busy_r;
  logic                  done_r;
  logic [4:0]            cnt_r;
  word_t                 q_r;
  word_t                 rem_r;
  word_t                 mb_r;
  logic                  neg_r;
  logic                  zero_r;
  logic [WORD_W:0]       rem_sh;
  logic [WORD_W:0]       diff;

  assign rem_sh = {rem_r, q_r[WORD_W-1]};
  assign diff   = rem_sh - {1'b0, mb_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else if (busy_r) begin
      cnt_r <= cnt_r + 5'd1;
      if (cnt_r == 5'd31) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end else begin
      done_r <= 1'b0;
    end
  end

  // datapath, magnitudes taken at start
  always_ff @(posedge clk) begin
    if (start) begin
      q_r    <= dividend[WORD_W-1] ? (word_t'(0) - dividend) : dividend;
      mb_r   <= divisor[WORD_W-1] ? (word_t'(0) - divisor) : divisor;
      rem_r  <= '0;
      neg_r  <= dividend[WORD_W-1] ^ divisor[WORD_W-1];
      zero_r <= (divisor == '0);
    end else if (busy_r) begin
      if (!diff[WORD_W]) begin
        rem_r <= diff[WORD_W-1:0];
        q_r   <= {q_r[WORD_W-2:0], 1'b1};
      end else begin
        rem_r <= rem_sh[WORD_W-1:0];
        q_r   <= {q_r[WORD_W-2:0], 1'b0};
      end
    end
  end

  assign done     = done_r;
  assign quotient = zero_r ? '1 : (neg_r ? (word_t'(0) - q_r) : q_r);

endmodule

### hw/rtl/toy_cpu_execute_unit_top.sv
// toy_cpu_execute_unit_top: execute stage of a small 32-bit isa
// depends on tce_pkg and tce_div
//
// sequence: for every opcode but div, operands are read at accept, then the execute state
//   computes the result and the commit state loads the output register; div also passes
//   through tce_div, which sets the quotient one bit per cycle, before done and commit
// flow: one transaction at a time; the next is taken once the result is committed to
//   the output register, even while that result still waits; a result that cannot
//   leave holds the commit
// reset: synchronous, active low; registers, pc and compare code read as zero
module toy_cpu_execute_unit_top
  import tce_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  // input channel
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [31:0]       in_instruction,
  input  logic [31:0]       in_load_word,
  // result channel
  output logic              out_valid,
  input  logic              out_stall,
  output logic [31:0]       out_next_pc,
  output logic              out_store_valid,
  output logic [23:0]       out_store_address,
  output logic [31:0]       out_store_data,
  output logic              out_reg_write_valid,
  output logic [3:0]        out_reg_index,
  output logic signed [31:0] out_reg_value,
  output logic signed [31:0] out_compare_code,
  output logic              out_halted
);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;  // waiting for a transaction
  localparam logic [1:0] S_EXEC = 2'd1;  // operands ready, non-div results computed, divider started
  localparam logic [1:0] S_DIV  = 2'd2;  // divider iterating
  localparam logic [1:0] S_FIN  = 2'd3;  // commit state and load output register

  logic [1:0] state_r, state_nxt;

  // latched transaction
  word_t    ins_r;
  word_t    lw_r;
  opcode_t  op;
  reg_idx_t fld_t;
  opcode_t  in_op;

  assign op     = ins_r[31:28];
  assign fld_t  = ins_r[27:24];
  assign in_op  = in_instruction[31:28];

  // architectural state
  word_t pc_r;
  word_t cmp_r;
  word_t res_r;

  // register file: two registered read ports, one write port
  // valid bits stand in for the all-zero reset
  word_t                rf_mem [NUM_REGS];
  logic [NUM_REGS-1:0]  rf_vld_r;
  reg_idx_t             rd_addr_a, rd_addr_b;
  word_t                rd_a_r, rd_b_r;
  logic                 rv_a_r, rv_b_r;
  word_t                opa, opb;
  logic                 rf_we;

  logic accept;
  logic out_free;
  logic div_start, div_done;
  word_t div_q;
  logic wr_v, st_v, take, halt;
  word_t res_nxt;
  word_t pc_nxt;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != S_IDLE);
  assign out_free = !out_valid || !out_stall;

  // store reads target through port a; cmp reads target and s1
  always_comb begin
    rd_addr_a = in_instruction[23:20];
    rd_addr_b = in_instruction[19:16];
    if (in_op == OPC_ST || in_op == OPC_CMP) begin
      rd_addr_a = in_instruction[27:24];
    end
    if (in_op == OPC_CMP) begin
      rd_addr_b = in_instruction[23:20];
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rd_a_r <= rf_mem[rd_addr_a];
      rd_b_r <= rf_mem[rd_addr_b];
    end
    if (rf_we) begin
      rf_mem[fld_t] <= res_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rf_vld_r <= '0;
      rv_a_r   <= 1'b0;
      rv_b_r   <= 1'b0;
    end else begin
      if (accept) begin
        rv_a_r <= rf_vld_r[rd_addr_a];
        rv_b_r <= rf_vld_r[rd_addr_b];
      end
      if (rf_we) begin
        rf_vld_r[fld_t] <= 1'b1;
      end
    end
  end

  assign opa = rv_a_r ? rd_a_r : '0;
  assign opb = rv_b_r ? rd_b_r : '0;

  // divider, started from the execute state for div
  assign div_start = (state_r == S_EXEC) && (op == OPC_DIV);

  tce_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (opa),
    .divisor  (opb),
    .done     (div_done),
    .quotient (div_q)
  );

  // combinational results for all ops but div; cmp difference also parks in res_r
  always_comb begin
    case (op)
      OPC_LD:  res_nxt = lw_r;
      OPC_ADD: res_nxt = opa + opb;
      OPC_SUB: res_nxt = opa - opb;
      OPC_MUL: res_nxt = opa * opb;
      OPC_AND: res_nxt = opa & opb;
      OPC_OR:  res_nxt = opa | opb;
      OPC_XOR: res_nxt = opa ^ opb;
      OPC_MOV: res_nxt = opa;
      OPC_CMP: res_nxt = opa - opb;
      default: res_nxt = '0;
    endcase
  end

  // commit-time decode
  always_comb begin
    wr_v = 1'b0;
    st_v = 1'b0;
    take = 1'b0;
    halt = 1'b0;
    case (op)
      OPC_LD, OPC_ADD, OPC_SUB, OPC_MUL, OPC_DIV,
      OPC_AND, OPC_OR, OPC_XOR, OPC_MOV: wr_v = 1'b1;
      OPC_ST:   st_v = 1'b1;
      OPC_CMP:  ;
      OPC_B:    take = 1'b1;
      OPC_BEQ:  take = (cmp_r == '0);
      OPC_BGT:  take = (cmp_r != '0) && !cmp_r[WORD_W-1];
      OPC_BLT:  take = cmp_r[WORD_W-1];
      default:  halt = 1'b1;
    endcase
  end

  always_comb begin
    if (halt) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = {{(WORD_W-ADDR_W){1'b0}}, ins_r[ADDR_W-1:0]};
    end else begin
      pc_nxt = pc_r + PC_STEP;
    end
  end

  assign rf_we = (state_r == S_FIN) && out_free && wr_v;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) state_nxt = S_EXEC;
      end
      S_EXEC: begin
        state_nxt = (op == OPC_DIV) ? S_DIV : S_FIN;
      end
      S_DIV: begin
        if (div_done) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      pc_r      <= '0;
      cmp_r     <= '0;
      out_valid <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_FIN && out_free) begin
        pc_r      <= pc_nxt;
        out_valid <= 1'b1;
        if (op == OPC_CMP) begin
          cmp_r <= res_r;
        end
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (accept) begin
      ins_r <= in_instruction;
      lw_r  <= in_load_word;
    end
    if (state_r == S_EXEC) begin
      res_r <= res_nxt;
    end else if (state_r == S_DIV && div_done) begin
      res_r <= div_q;
    end
    if (state_r == S_FIN && out_free) begin
      out_next_pc         <= pc_nxt;
      out_store_valid     <= st_v;
      out_store_address   <= st_v ? ins_r[ADDR_W-1:0] : '0;
      out_store_data      <= st_v ? opa : '0;
      out_reg_write_valid <= wr_v;
      out_reg_index       <= wr_v ? fld_t : '0;
      out_reg_value       <= wr_v ? res_r : '0;
      out_compare_code    <= (op == OPC_CMP) ? res_r : cmp_r;
      out_halted          <= halt;
    end
  end

endmodule
